/* design/lir_pkg.sv */
// ----------------------------------------------------------------------------
// lir_pkg
// Shared widths, register indexes, microcode format and control program
// for the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    // Data widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int DIFF_W       = SAMPLE_WIDTH + 1;
    localparam int RATE_W       = 17;
    localparam int PHASE_W      = RATE_W + 1;
    localparam int PROD_W       = DIFF_W + RATE_W;
    localparam int DIV_CNT_W    = $clog2(DIFF_W);
    localparam int MAX_RUN      = 12;
    localparam int RUN_CNT_W    = $clog2(MAX_RUN + 1);

    // Rate limits and reset values
    localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(8000);
    localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(96000);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_RATE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_RATE = 1'b1;

    // Datapath operations
    localparam logic [3:0] OP_NOP        = 4'd0;
    localparam logic [3:0] OP_LOAD       = 4'd1;
    localparam logic [3:0] OP_START      = 4'd2;
    localparam logic [3:0] OP_DIFF       = 4'd3;
    localparam logic [3:0] OP_MUL        = 4'd4;
    localparam logic [3:0] OP_DIVINIT    = 4'd5;
    localparam logic [3:0] OP_DIVSTEP    = 4'd6;
    localparam logic [3:0] OP_EMIT       = 4'd7;
    localparam logic [3:0] OP_EMIT_EMPTY = 4'd8;
    localparam logic [3:0] OP_EMIT_PASS  = 4'd9;
    localparam logic [3:0] OP_FIN        = 4'd10;

    // Jump conditions
    localparam logic [2:0] JC_NEVER     = 3'd0;
    localparam logic [2:0] JC_ALWAYS    = 3'd1;
    localparam logic [2:0] JC_IN_IDLE   = 3'd2;
    localparam logic [2:0] JC_RATES_EQ  = 3'd3;
    localparam logic [2:0] JC_LOOP_DONE = 3'd4;
    localparam logic [2:0] JC_DIV_MORE  = 3'd5;
    localparam logic [2:0] JC_OUT_FULL  = 3'd6;
    localparam logic [2:0] JC_RUN_SEEN  = 3'd7;

    // Program step addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] ST_WAIT      = 4'd0;
    localparam logic [PC_W-1:0] ST_CHECK     = 4'd1;
    localparam logic [PC_W-1:0] ST_START     = 4'd2;
    localparam logic [PC_W-1:0] ST_TEST      = 4'd3;
    localparam logic [PC_W-1:0] ST_MUL       = 4'd4;
    localparam logic [PC_W-1:0] ST_DIVINIT   = 4'd5;
    localparam logic [PC_W-1:0] ST_DIVSTEP   = 4'd6;
    localparam logic [PC_W-1:0] ST_EMIT      = 4'd7;
    localparam logic [PC_W-1:0] ST_LOOP      = 4'd8;
    localparam logic [PC_W-1:0] ST_FIN       = 4'd9;
    localparam logic [PC_W-1:0] ST_EMPTY     = 4'd10;
    localparam logic [PC_W-1:0] ST_EMPTY_RET = 4'd11;
    localparam logic [PC_W-1:0] ST_PASS      = 4'd12;
    localparam logic [PC_W-1:0] ST_PASS_RET  = 4'd13;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic rates_eq;
        logic loop_done;
        logic div_more;
        logic out_full;
        logic run_seen;
    } dp_status_t;

    // Control store: one word per program step
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: JC_ALWAYS, target: ST_WAIT};
        unique case (pc)
            ST_WAIT:      w = '{op: OP_LOAD,       cond: JC_IN_IDLE,   target: ST_WAIT};
            ST_CHECK:     w = '{op: OP_NOP,        cond: JC_RATES_EQ,  target: ST_PASS};
            ST_START:     w = '{op: OP_START,      cond: JC_NEVER,     target: ST_WAIT};
            ST_TEST:      w = '{op: OP_DIFF,       cond: JC_LOOP_DONE, target: ST_FIN};
            ST_MUL:       w = '{op: OP_MUL,        cond: JC_NEVER,     target: ST_WAIT};
            ST_DIVINIT:   w = '{op: OP_DIVINIT,    cond: JC_NEVER,     target: ST_WAIT};
            ST_DIVSTEP:   w = '{op: OP_DIVSTEP,    cond: JC_DIV_MORE,  target: ST_DIVSTEP};
            ST_EMIT:      w = '{op: OP_EMIT,       cond: JC_OUT_FULL,  target: ST_EMIT};
            ST_LOOP:      w = '{op: OP_NOP,        cond: JC_ALWAYS,    target: ST_TEST};
            ST_FIN:       w = '{op: OP_FIN,        cond: JC_RUN_SEEN,  target: ST_WAIT};
            ST_EMPTY:     w = '{op: OP_EMIT_EMPTY, cond: JC_OUT_FULL,  target: ST_EMPTY};
            ST_EMPTY_RET: w = '{op: OP_NOP,        cond: JC_ALWAYS,    target: ST_WAIT};
            ST_PASS:      w = '{op: OP_EMIT_PASS,  cond: JC_OUT_FULL,  target: ST_PASS};
            ST_PASS_RET:  w = '{op: OP_NOP,        cond: JC_ALWAYS,    target: ST_WAIT};
            default:      w = '{op: OP_NOP,        cond: JC_ALWAYS,    target: ST_WAIT};
        endcase
        return w;
    endfunction

    // Limit a rate to the supported range
    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
        logic [RATE_W-1:0] c;
        c = r;
        priority if (r < RATE_MIN)
            c = RATE_MIN;
        else if (r > RATE_MAX)
            c = RATE_MAX;
        else
            c = r;
        return c;
    endfunction

endpackage

/* design/lir_sequencer.sv */
// ----------------------------------------------------------------------------
// lir_sequencer
// Step counter over the control store; picks the next step from the
// jump condition of the current word and the datapath status.
// ----------------------------------------------------------------------------
module lir_sequencer
    import lir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output ctrl_word_t ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take_jump;

    // Fetch the current control word
    assign ctrl = ucode_rom(pc_reg);

    // Evaluate the jump condition
    always_comb
    begin
        take_jump = 1'b0;
        unique case (ctrl.cond)
            JC_NEVER:     take_jump = 1'b0;
            JC_ALWAYS:    take_jump = 1'b1;
            JC_IN_IDLE:   take_jump = !status.in_valid;
            JC_RATES_EQ:  take_jump = status.rates_eq;
            JC_LOOP_DONE: take_jump = status.loop_done;
            JC_DIV_MORE:  take_jump = status.div_more;
            JC_OUT_FULL:  take_jump = status.out_full;
            JC_RUN_SEEN:  take_jump = status.run_seen;
        endcase
        pc_next = take_jump ? ctrl.target : pc_reg + PC_W'(1);
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= ST_WAIT;
        else
            pc_reg <= pc_next;
    end

endmodule

/* design/lir_datapath.sv */
// ----------------------------------------------------------------------------
// lir_datapath
// Sample and phase state, one 17x17 multiplier, a restoring divider that
// retires one quotient bit a step, and the output register.
// ----------------------------------------------------------------------------
module lir_datapath
    import lir_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_word_t              ctrl,
    output dp_status_t              status,
    input  logic [RATE_W-1:0]       in_rate,
    input  logic [RATE_W-1:0]       out_rate,
    input  logic                    in_valid,
    input  logic [SAMPLE_WIDTH-1:0] in_sample,
    input  logic                    in_frame_start,
    input  logic                    in_keep_previous,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SAMPLE_WIDTH-1:0] out_sample,
    output logic                    run_last,
    output logic                    run_empty
);

    // Per-item and loop state
    logic [SAMPLE_WIDTH-1:0] cur_reg, cur_next;
    logic                    start_reg, start_next;
    logic                    keep_reg, keep_next;
    logic [RATE_W-1:0]       ir_reg, ir_next;
    logic [RATE_W-1:0]       or_reg, or_next;
    logic [SAMPLE_WIDTH-1:0] prev_reg, prev_next;
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic [DIFF_W-1:0]       dmag_reg, dmag_next;
    logic                    dneg_reg, dneg_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [RATE_W-1:0]       rem_reg, rem_next;
    logic [DIFF_W-1:0]       quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]    dcnt_reg, dcnt_next;
    logic [RUN_CNT_W-1:0]    n_reg, n_next;

    // Output register
    logic                    ovalid_reg, ovalid_next;
    logic [SAMPLE_WIDTH-1:0] osample_reg, osample_next;
    logic                    olast_reg, olast_next;
    logic                    oempty_reg, oempty_next;

    // Helpers
    logic                    out_full;
    logic                    emit_ok;
    logic [DIFF_W-1:0]       diff;
    logic [RATE_W:0]         div_shift;
    logic                    div_ge;
    logic [DIFF_W-1:0]       q_signed;
    logic [DIFF_W-1:0]       interp;
    logic [PHASE_W-1:0]      phase_adv;

    assign out_full = ovalid_reg && !out_ready;
    assign emit_ok  = !out_full;

    assign diff      = {cur_reg[SAMPLE_WIDTH-1], cur_reg} - {prev_reg[SAMPLE_WIDTH-1], prev_reg};
    assign div_shift = {rem_reg, quo_reg[DIFF_W-1]};
    assign div_ge    = div_shift >= {1'b0, or_reg};
    assign q_signed  = dneg_reg ? -quo_reg : quo_reg;
    assign interp    = {prev_reg[SAMPLE_WIDTH-1], prev_reg} + q_signed;
    assign phase_adv = PHASE_W'({1'b0, phase_reg} + {{(PHASE_W - RATE_W + 1){1'b0}}, ir_reg});

    // Status back to the sequencer
    assign status.in_valid  = in_valid;
    assign status.rates_eq  = ir_reg == or_reg;
    assign status.loop_done = (phase_reg >= {1'b0, or_reg})
                              || (n_reg == RUN_CNT_W'(MAX_RUN));
    assign status.div_more  = dcnt_reg != DIV_CNT_W'(DIFF_W - 1);
    assign status.out_full  = out_full;
    assign status.run_seen  = n_reg != '0;

    // Execute the current control word
    always_comb
    begin
        cur_next     = cur_reg;
        start_next   = start_reg;
        keep_next    = keep_reg;
        ir_next      = ir_reg;
        or_next      = or_reg;
        prev_next    = prev_reg;
        phase_next   = phase_reg;
        dmag_next    = dmag_reg;
        dneg_next    = dneg_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        n_next       = n_reg;
        osample_next = osample_reg;
        olast_next   = olast_reg;
        oempty_next  = oempty_reg;
        ovalid_next  = ovalid_reg && !out_ready;

        unique case (ctrl.op)
            OP_LOAD:
            begin
                // latch the transaction and the limited rates
                if (in_valid)
                begin
                    cur_next   = in_sample;
                    start_next = in_frame_start;
                    keep_next  = in_keep_previous;
                    ir_next    = clamp_rate(in_rate);
                    or_next    = clamp_rate(out_rate);
                end
            end
            OP_START:
            begin
                if (start_reg)
                begin
                    phase_next = '0;
                    if (!keep_reg)
                        prev_next = cur_reg;
                end
                n_next = '0;
            end
            OP_DIFF:
            begin
                dneg_next = diff[DIFF_W-1];
                dmag_next = diff[DIFF_W-1] ? -diff : diff;
            end
            OP_MUL:
            begin
                // phase is below out_rate here, so its low bits suffice
                prod_next = PROD_W'(dmag_reg) * PROD_W'(phase_reg[RATE_W-1:0]);
            end
            OP_DIVINIT:
            begin
                // high part is already below the divisor
                rem_next  = prod_reg[PROD_W-1:DIFF_W];
                quo_next  = prod_reg[DIFF_W-1:0];
                dcnt_next = '0;
            end
            OP_DIVSTEP:
            begin
                rem_next  = div_ge ? RATE_W'(div_shift - {1'b0, or_reg})
                                   : div_shift[RATE_W-1:0];
                quo_next  = {quo_reg[DIFF_W-2:0], div_ge};
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
            end
            OP_EMIT:
            begin
                // hold until the output slot frees, then advance phase
                if (emit_ok)
                begin
                    ovalid_next  = 1'b1;
                    osample_next = interp[SAMPLE_WIDTH-1:0];
                    olast_next   = (phase_adv >= {1'b0, or_reg})
                                   || (n_reg == RUN_CNT_W'(MAX_RUN - 1));
                    oempty_next  = 1'b0;
                    phase_next   = phase_adv;
                    n_next       = n_reg + RUN_CNT_W'(1);
                end
            end
            OP_EMIT_EMPTY:
            begin
                if (emit_ok)
                begin
                    ovalid_next  = 1'b1;
                    osample_next = '0;
                    olast_next   = 1'b0;
                    oempty_next  = 1'b1;
                end
            end
            OP_EMIT_PASS:
            begin
                if (emit_ok)
                begin
                    ovalid_next  = 1'b1;
                    osample_next = cur_reg;
                    olast_next   = 1'b1;
                    oempty_next  = 1'b0;
                end
            end
            OP_FIN:
            begin
                // move to the next input interval
                if (phase_reg >= {1'b0, or_reg})
                    phase_next = phase_reg - {1'b0, or_reg};
                else
                    phase_next = '0;
                prev_next = cur_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            phase_reg  <= '0;
            n_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            prev_reg   <= prev_next;
            phase_reg  <= phase_next;
            n_reg      <= n_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        start_reg   <= start_next;
        keep_reg    <= keep_next;
        ir_reg      <= ir_next;
        or_reg      <= or_next;
        dmag_reg    <= dmag_next;
        dneg_reg    <= dneg_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dcnt_reg    <= dcnt_next;
        osample_reg <= osample_next;
        olast_reg   <= olast_next;
        oempty_reg  <= oempty_next;
    end

    assign out_valid  = ovalid_reg;
    assign out_sample = osample_reg;
    assign run_last   = olast_reg;
    assign run_empty  = oempty_reg;

endmodule

/* design/linear_interp_resampler_core.sv */
// ----------------------------------------------------------------------------
// linear_interp_resampler_core
// Linear interpolation sample-rate converter, microcoded control.
// ----------------------------------------------------------------------------
// Each accepted sample yields one or more output transactions; the last one
// of a run carries tlast, and a sample that yields no output gives a single
// transaction with tuser set. A sample yields at most twelve outputs. For
// every output the divider retires one of 17 quotient bits per cycle, and
// an emit stalls while the output side holds tready low with a result
// waiting. A new sample is accepted only while the sequencer waits at its
// first step; a finished output may still wait in the output register then.
// Rates must be written on the configuration port only while the block is
// idle; the block itself does not enforce this.
module linear_interp_resampler_core
    import lir_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [RATE_W-1:0]       cfg_wdata,
    // input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_WIDTH-1:0] s_axis_tdata,   // [15:0] sample
    input  logic [1:0]              s_axis_tuser,   // [0] frame_start, [1] keep_previous
    // output stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [SAMPLE_WIDTH-1:0] m_axis_tdata,   // [15:0] out_sample
    output logic                    m_axis_tlast,   // run_last
    output logic                    m_axis_tuser    // [0] run_empty
);

    logic [RATE_W-1:0] in_rate_reg, in_rate_next;
    logic [RATE_W-1:0] out_rate_reg, out_rate_next;
    ctrl_word_t        ctrl;
    dp_status_t        status;

    // Decode configuration writes
    always_comb
    begin
        in_rate_next  = in_rate_reg;
        out_rate_next = out_rate_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IN_RATE:  in_rate_next  = cfg_wdata;
                REG_OUT_RATE: out_rate_next = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rate_reg  <= RATE_RESET;
            out_rate_reg <= RATE_RESET;
        end
        else
        begin
            in_rate_reg  <= in_rate_next;
            out_rate_reg <= out_rate_next;
        end
    end

    // Accept a transaction only at the load step
    assign s_axis_tready = ctrl.op == OP_LOAD;

    lir_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    lir_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .status           (status),
        .in_rate          (in_rate_reg),
        .out_rate         (out_rate_reg),
        .in_valid         (s_axis_tvalid),
        .in_sample        (s_axis_tdata),
        .in_frame_start   (s_axis_tuser[0]),
        .in_keep_previous (s_axis_tuser[1]),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_sample       (m_axis_tdata),
        .run_last         (m_axis_tlast),
        .run_empty        (m_axis_tuser)
    );

endmodule
